>>> hdl/abesl_pkg.sv
// Shared constants, types and helper functions for the air-band exciter slew limiter.
package abesl_pkg;

  // Shared multiplier operand and product widths.
  localparam int MulAW = 36;
  localparam int MulBW = 26;
  localparam int MulPW = MulAW + MulBW;
  // Wide accumulator width: a product with its 18 fraction bits dropped.
  localparam int AccW  = MulPW - 18;

  localparam int OneQ18 = 262144;

  // Cosine shaping table.
  localparam int CosLog2  = 8;
  localparam int CosDepth = 1 << CosLog2;
  localparam int CosIdxW  = CosLog2 + 1;
  localparam int CosW     = 19;

  typedef logic [CosW-1:0] cos_tbl_t [0:CosDepth];

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgAirBandGain     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGroundBandGain  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSlewThreshold   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlewDepth       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAdaptiveGainCap = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGroundDryCoef   = 3'd5;

  localparam logic [23:0] RstAirBandGain     = 24'd262144;
  localparam logic [19:0] RstGroundBandGain  = 20'd262144;
  localparam logic [18:0] RstSlewThreshold   = 19'd262144;
  localparam logic [18:0] RstSlewDepth       = 19'd0;
  localparam logic [18:0] RstAdaptiveGainCap = 19'd78643;
  localparam logic [18:0] RstGroundDryCoef   = 19'd115343;

  localparam logic signed [AccW-1:0] Sat32Max = AccW'(32'sh7fffffff);
  localparam logic signed [AccW-1:0] Sat32Min = AccW'(32'sh80000000);

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [31:0] r;
    if (v > Sat32Max) begin
      r = 32'sh7fffffff;
    end else if (v < Sat32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Truncated cosine series in Q.30, rounded to Q.18, for t = i / CosDepth.
  function automatic cos_tbl_t cos_build();
    cos_tbl_t        tbl;
    longint unsigned th;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    for (int i = 0; i <= CosDepth; i++) begin
      th   = 64'(i) << (30 - CosLog2);
      t2   = (th * th) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      term = ((term * t2) >> 30) / 2;
      sum  = sum - signed'(term);
      term = ((term * t2) >> 30) / 12;
      sum  = sum + signed'(term);
      term = ((term * t2) >> 30) / 30;
      sum  = sum - signed'(term);
      term = ((term * t2) >> 30) / 56;
      sum  = sum + signed'(term);
      tbl[i] = CosW'((sum + 64'sd2048) >>> 12);
    end
    return tbl;
  endfunction

  localparam cos_tbl_t CosTbl = cos_build();

endpackage

>>> hdl/air_band_exciter_slew_limit_unit.sv
// Air-band exciter with cosine-shaped slew limiter: sequencer around one shared multiplier.
// One mono sample enters per input beat and one result beat (sample plus clip flag) comes
// back for it. The block works on one sample at a time. The result of an accepted sample is
// registered at the output once the sample has gone through every step of the sequence, and
// the next sample is taken only once the sequencer is back in its idle step. The reason is
// that all eight products of the algorithm go one after another through a single 36x26-bit
// multiplier whose product is registered. in_stall is high while a sample is worked on.
// The output register holds a finished result while the next sample is already accepted;
// a result still stalled at the end of the next sample holds the sequencer in its last step.
// Configuration writes are meant to happen while no sample is in flight.
module air_band_exciter_slew_limit_unit #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       out_sample_out,
  output logic                                 out_clipped,
  input  logic                                 cfg_write_en,
  input  logic [abesl_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [abesl_pkg::CfgDataW-1:0]       cfg_data
);

  localparam int AccW    = abesl_pkg::AccW;
  localparam int MulAW   = abesl_pkg::MulAW;
  localparam int MulBW   = abesl_pkg::MulBW;
  localparam int MulPW   = abesl_pkg::MulPW;
  localparam int CosIdxW = abesl_pkg::CosIdxW;
  localparam int GW      = AccW + 18;
  localparam int SW      = SAMPLE_WIDTH;
  // Rescale of |slew_last| to Q.16 for the cosine index.
  localparam int QShR    = (SW >= 17) ? SW - 17 : 0;
  localparam int QShL    = (SW >= 17) ? 0 : 17 - SW;
  localparam int IdxShift = 32 - abesl_pkg::CosLog2;

  localparam logic signed [AccW-1:0]  FsPos  = AccW'(64'sd1 <<< (SW - 1));
  localparam logic signed [AccW-1:0]  FsNeg  = -FsPos;
  localparam logic signed [AccW-1:0]  FsMax  = FsPos - AccW'(1);
  localparam logic signed [MulBW-1:0] OneQ18 = MulBW'(abesl_pkg::OneQ18);

  typedef enum logic [3:0] {
    StIdle,
    StPredA,
    StPredB,
    StGain,
    StHist,
    StH1,
    StAir,
    StMix,
    StSlew,
    StLim,
    StWet,
    StOut
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [23:0] air_gain_r;
  logic [19:0] ground_gain_r;
  logic [18:0] slew_thr_r;
  logic [18:0] slew_depth_r;
  logic [18:0] gain_cap_r;
  logic [18:0] ground_dry_r;

  // Algorithm state.
  logic signed [31:0] h1_r, h2_r, h3_r, h4_r;
  logic        [23:0] g_r;
  logic signed [31:0] gp_r;
  logic signed [SW:0] sl_r;

  // Output register.
  logic                 out_valid_r;
  logic signed [SW-1:0] out_sample_r;
  logic                 out_clipped_r;

  // Datapath temporaries.
  logic signed [SW-1:0]      x_r;
  logic signed [MulPW-1:0]   prod_r;
  logic signed [AccW-1:0]    u_r, w_r, p_r, xg_r, a1_r, wet_r;
  logic [CosIdxW-1:0]        cidx_r;
  logic [abesl_pkg::CosW-1:0] cos_r;
  logic signed [31:0]        d_r, v_r, m_r;
  logic [18:0]               step_r;
  logic signed [SW:0]        t_r;

  // Combinational.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [AccW-1:0]  prod_sh;
  logic signed [AccW-1:0]  xw, h1w, h2w, h3w, h4w, vw, mw, slw, tw, stw;
  logic signed [AccW-1:0]  u_nxt, w_nxt, p_nxt, err_diff, xmv, v_sum;
  logic        [AccW-1:0]  err_abs;
  logic        [GW-1:0]    g_term, g_sum;
  logic        [23:0]      g_nxt;
  logic signed [31:0]      d_nxt, v_nxt, h1_nxt, m_nxt;
  logic        [SW:0]      sl_abs;
  logic        [16:0]      q;
  logic        [MulPW-1:0] idx_w;
  logic [CosIdxW-1:0]      cidx_nxt;
  logic signed [AccW-1:0]  t_clamp, lim_diff, lim_t, sl_clamp, y_nxt, ys_nxt;
  logic signed [SW:0]      t_nxt, sl_nxt;
  logic signed [MulBW-1:0] depth_b, one_m_depth;
  logic                    clip_nxt;
  logic                    out_free;

  assign prod_sh = prod_r[MulPW-1:18];
  assign xw      = AccW'(x_r);
  assign h1w     = AccW'(h1_r);
  assign h2w     = AccW'(h2_r);
  assign h3w     = AccW'(h3_r);
  assign h4w     = AccW'(h4_r);
  assign vw      = AccW'(v_r);
  assign mw      = AccW'(m_r);
  assign slw     = AccW'(sl_r);
  assign tw      = AccW'(t_r);
  assign stw     = AccW'(step_r);
  assign depth_b = MulBW'(slew_depth_r);
  assign one_m_depth = OneQ18 - depth_b;

  // Prediction p = (b2 + b1) / 2 - (h1 + s3 + b2), with the differences folded.
  assign u_nxt = h4w - (h3w <<< 1) + (h1w <<< 1) - xw;
  assign w_nxt = h4w - (h3w <<< 1) + (h2w <<< 1);
  assign p_nxt = (u_r >>> 1) - w_r;

  // Adaptive gain follows half the old gain plus the scaled absolute error, capped at the adaptive gain cap.
  assign err_diff = xw - p_r;
  assign err_abs  = err_diff[AccW-1] ? -err_diff : err_diff;
  assign g_term   = {err_abs, 18'b0} >> SW;
  assign g_sum    = GW'(g_r >> 1) + g_term;
  assign g_nxt    = (g_sum > GW'(gain_cap_r)) ? 24'(gain_cap_r) : g_sum[23:0];

  assign d_nxt  = abesl_pkg::sat32(xw - ((p_r >>> 1) + xg_r));
  assign v_sum  = AccW'(d_r) + AccW'(gp_r);
  assign v_nxt  = v_sum[32:1];
  assign h1_nxt = abesl_pkg::sat32(prod_sh + xw);
  assign xmv    = xw - vw;
  assign m_nxt  = abesl_pkg::sat32(a1_r + prod_sh);

  // Cosine table index from the squared magnitude of the last limiter output.
  assign sl_abs = sl_r[SW] ? -sl_r : sl_r;
  assign q      = 17'((sl_abs >> QShR) << QShL);
  assign idx_w  = prod_r >> IdxShift;
  assign cidx_nxt = (idx_w > MulPW'(abesl_pkg::CosDepth)) ?
                    CosIdxW'(abesl_pkg::CosDepth) : idx_w[CosIdxW-1:0];

  always_comb begin
    if (mw > FsPos) begin
      t_clamp = FsPos;
    end else if (mw < FsNeg) begin
      t_clamp = FsNeg;
    end else begin
      t_clamp = mw;
    end
  end
  assign t_nxt = (SW+1)'(t_clamp);

  // Step limit around the previous limiter output, then clamp to full scale.
  assign lim_diff = tw - slw;
  always_comb begin
    priority if (lim_diff > stw) begin
      lim_t = slw + stw;
    end else if (lim_diff < -stw) begin
      lim_t = slw - stw;
    end else begin
      lim_t = tw;
    end
  end
  always_comb begin
    if (lim_t > FsPos) begin
      sl_clamp = FsPos;
    end else if (lim_t < FsNeg) begin
      sl_clamp = FsNeg;
    end else begin
      sl_clamp = lim_t;
    end
  end
  assign sl_nxt = (SW+1)'(sl_clamp);

  assign y_nxt = wet_r + prod_sh;
  always_comb begin
    if (y_nxt > FsMax) begin
      ys_nxt = FsMax;
    end else if (y_nxt < FsNeg) begin
      ys_nxt = FsNeg;
    end else begin
      ys_nxt = y_nxt;
    end
  end
  assign clip_nxt = (ys_nxt != y_nxt);

  // Operand select for the shared multiplier; the product is used one state later.
  always_comb begin
    unique case (state_r)
      StPredA: begin
        mul_a = MulAW'(x_r);
        mul_b = MulBW'(ground_dry_r);
      end
      StPredB: begin
        mul_a = MulAW'(q);
        mul_b = MulBW'(q);
      end
      StHist: begin
        mul_a = MulAW'(p_r);
        mul_b = MulBW'(g_r);
      end
      StH1: begin
        mul_a = MulAW'(xmv);
        mul_b = MulBW'(air_gain_r);
      end
      StAir: begin
        mul_a = MulAW'(v_r);
        mul_b = MulBW'(ground_gain_r);
      end
      StMix: begin
        mul_a = MulAW'(cos_r);
        mul_b = MulBW'(slew_thr_r);
      end
      StSlew: begin
        mul_a = MulAW'(m_r);
        mul_b = one_m_depth;
      end
      StWet, StOut: begin
        // Held while the result waits, so the product stays put.
        mul_a = MulAW'(sl_r);
        mul_b = depth_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= StIdle;
      out_valid_r   <= 1'b0;
      out_sample_r  <= '0;
      out_clipped_r <= 1'b0;
      air_gain_r    <= abesl_pkg::RstAirBandGain;
      ground_gain_r <= abesl_pkg::RstGroundBandGain;
      slew_thr_r    <= abesl_pkg::RstSlewThreshold;
      slew_depth_r  <= abesl_pkg::RstSlewDepth;
      gain_cap_r    <= abesl_pkg::RstAdaptiveGainCap;
      ground_dry_r  <= abesl_pkg::RstGroundDryCoef;
      h1_r          <= '0;
      h2_r          <= '0;
      h3_r          <= '0;
      h4_r          <= '0;
      g_r           <= '0;
      gp_r          <= '0;
      sl_r          <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          abesl_pkg::CfgAirBandGain:     air_gain_r    <= cfg_data[23:0];
          abesl_pkg::CfgGroundBandGain:  ground_gain_r <= cfg_data[19:0];
          abesl_pkg::CfgSlewThreshold:   slew_thr_r    <= cfg_data[18:0];
          abesl_pkg::CfgSlewDepth:       slew_depth_r  <= cfg_data[18:0];
          abesl_pkg::CfgAdaptiveGainCap: gain_cap_r    <= cfg_data[18:0];
          abesl_pkg::CfgGroundDryCoef:   ground_dry_r  <= cfg_data[18:0];
          default: ;
        endcase
      end

      // In the last step the output register is reloaded below instead.
      if (out_valid_r && !out_stall && (state_r != StOut)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        StIdle: begin
          if (in_valid) begin
            state_r <= StPredA;
          end
        end
        StPredA: state_r <= StPredB;
        StPredB: state_r <= StGain;
        StGain: begin
          g_r     <= g_nxt;
          state_r <= StHist;
        end
        StHist: begin
          gp_r    <= d_r;
          state_r <= StH1;
        end
        StH1: begin
          h4_r    <= h3_r;
          h3_r    <= h2_r;
          h2_r    <= h1_r;
          h1_r    <= h1_nxt;
          state_r <= StAir;
        end
        StAir:  state_r <= StMix;
        StMix:  state_r <= StSlew;
        StSlew: state_r <= StLim;
        StLim: begin
          sl_r    <= sl_nxt;
          state_r <= StWet;
        end
        StWet:  state_r <= StOut;
        StOut: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_sample_r  <= SW'(ys_nxt);
            out_clipped_r <= clip_nxt;
            state_r       <= StIdle;
          end
        end
        default: state_r <= StIdle;
      endcase
    end
  end

  // Datapath registers, loaded by step of the sequence.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      StIdle: begin
        x_r <= in_sample_in;
      end
      StPredA: begin
        u_r <= u_nxt;
        w_r <= w_nxt;
      end
      StPredB: begin
        p_r  <= p_nxt;
        xg_r <= prod_sh;
      end
      StGain: begin
        cidx_r <= cidx_nxt;
        d_r    <= d_nxt;
      end
      StHist: begin
        cos_r <= abesl_pkg::CosTbl[cidx_r];
        v_r   <= v_nxt;
      end
      StAir: begin
        a1_r <= prod_sh;
      end
      StMix: begin
        m_r <= m_nxt;
      end
      StSlew: begin
        step_r <= prod_r[36:18];
        t_r    <= t_nxt;
      end
      StLim: begin
        wet_r <= prod_sh;
      end
      default: ;
    endcase
  end

  assign in_stall       = (state_r != StIdle);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

>>> hdl/abesl_checker.sv
// Port-level assertions for the air-band exciter slew limiter, bound to its top level.
module abesl_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                    out_clipped
);

  localparam logic [SAMPLE_WIDTH-1:0] RailHi = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] RailLo = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // An accepted sample leaves the block busy, so no sample is accepted right after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in two consecutive cycles");

  // A new result is only ever produced at the end of a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

  // A clipped result sits on one of the two rails.
  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_sample_out == RailHi) || (out_sample_out == RailLo))
    else $error("clip flag set on a sample that is not at a rail");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out) && $stable(out_clipped))
    else $error("stalled result beat changed");

endmodule

bind air_band_exciter_slew_limit_unit abesl_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_abesl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped)
);
